// ===== sv/tdac_pkg.sv =====
package tdac_pkg;

  localparam int unsigned CURSOR_PIXELS_PER_ITEM = 4;
  localparam int unsigned LANES     = 4;
  localparam int unsigned REG_COUNT = 16;

  localparam int unsigned IN_BITS  = 152;
  localparam int unsigned OUT_BITS = 144;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_CURSOR = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CUR_COLOUR0 = 2'd0,
    CUR_COLOUR1 = 2'd1,
    CUR_SCREEN  = 2'd2,
    CUR_INVERT  = 2'd3
  } cursor_code_t;

  typedef enum logic [2:0] {
    FMT_8BPP  = 3'd0,
    FMT_4BPP  = 3'd1,
    FMT_15BPP = 3'd2,
    FMT_16BPP = 3'd3,
    FMT_24BPP = 3'd4,
    FMT_32BPP = 3'd5,
    FMT_ABGR  = 3'd6,
    FMT_RGBA  = 3'd7
  } fmt_t;

  // register indices with side effects
  localparam logic [3:0] IDX_CURSOR_INDEX = 4'h4;
  localparam logic [3:0] IDX_CURSOR_DATA  = 4'h5;
  localparam logic [3:0] IDX_FORMAT       = 4'hB;
  localparam logic [3:0] IDX_CONTROL      = 4'hC;

  localparam logic [7:0] ID_A = 8'h02;
  localparam logic [7:0] ID_B = 8'h1D;
  localparam logic [7:0] ID_C = 8'hD0;

  localparam logic [23:0] RGB_MASK = 24'hFF_FFFF;

  // bus access as seen by the register block
  typedef struct packed {
    op_t        op;
    logic [3:0] idx;
    logic [7:0] wdata;
  } bus_req_t;

  // cursor colours as they are shown
  typedef struct packed {
    logic [23:0] colour1;
    logic [23:0] colour0;
  } cursor_cols_t;

  function automatic logic [7:0] widen6(input logic [7:0] c);
    return {c[5:0], c[5:4]};
  endfunction

  function automatic fmt_t decode_format(input logic [7:0] v);
    fmt_t f;
    case (v) inside
      8'h82:        f = FMT_4BPP;
      8'hA0, 8'hB0: f = FMT_15BPP;
      8'hA1, 8'hB1: f = FMT_16BPP;
      8'hC0, 8'hD0: f = FMT_24BPP;
      8'hE2, 8'hF7: f = FMT_32BPP;
      8'hE3:        f = FMT_ABGR;
      8'hF2:        f = FMT_RGBA;
      default:      f = FMT_8BPP;
    endcase
    return f;
  endfunction

endpackage

// ===== sv/tdac_regs.sv =====
module tdac_regs (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  tdac_pkg::bus_req_t     req,
  output logic [7:0]             read_data,
  output logic                   forward_to_vga,
  output tdac_pkg::fmt_t         pixel_format,
  output tdac_pkg::cursor_cols_t cols
);

  logic [7:0]  rf [tdac_pkg::REG_COUNT];
  logic [7:0]  colour_index;
  logic [1:0]  write_phase;
  logic [7:0]  latched_red;
  logic [7:0]  latched_green;
  logic [23:0] cursor_colours [2];

  logic       is_vga;
  logic       do_write;
  logic [7:0] fmt_byte;

  assign is_vga   = (req.idx < 4'd4);
  assign do_write = accept && (req.op == tdac_pkg::OP_WRITE) && !is_vga;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tdac_pkg::REG_COUNT; i++) rf[i] <= '0;
      colour_index      <= '0;
      write_phase       <= '0;
      latched_red       <= '0;
      latched_green     <= '0;
      cursor_colours[0] <= '0;
      cursor_colours[1] <= '0;
    end else if (do_write) begin
      rf[req.idx] <= req.wdata;
      if (req.idx == tdac_pkg::IDX_CURSOR_INDEX) begin
        colour_index <= req.wdata;
        write_phase  <= 2'd0;
      end else if (req.idx == tdac_pkg::IDX_CURSOR_DATA) begin
        case (write_phase)
          2'd0: begin
            latched_red <= req.wdata;
            write_phase <= 2'd1;
          end
          2'd1: begin
            latched_green <= req.wdata;
            write_phase   <= 2'd2;
          end
          2'd2: begin
            // blue commits only to colour 0 or 1, otherwise the beat is dropped
            if (colour_index <= 8'd1) begin
              cursor_colours[colour_index[0]] <= {latched_red, latched_green, req.wdata};
              write_phase  <= 2'd0;
              colour_index <= colour_index + 8'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    read_data      = '0;
    forward_to_vga = 1'b0;
    if (req.op == tdac_pkg::OP_WRITE || req.op == tdac_pkg::OP_READ) begin
      if (is_vga) begin
        forward_to_vga = 1'b1;
      end else if (req.op == tdac_pkg::OP_READ) begin
        case (req.idx) inside
          4'h4, 4'h8: read_data = tdac_pkg::ID_A;
          4'h6, 4'hA: read_data = tdac_pkg::ID_B;
          4'hF:       read_data = tdac_pkg::ID_C;
          default:    read_data = rf[req.idx];
        endcase
      end
    end
  end

  // format reflects a write to the format register in the same beat
  assign fmt_byte = (do_write && req.idx == tdac_pkg::IDX_FORMAT) ? req.wdata
                                                                  : rf[tdac_pkg::IDX_FORMAT];
  assign pixel_format = tdac_pkg::decode_format(fmt_byte);

  always_comb begin
    cols.colour0 = cursor_colours[0];
    cols.colour1 = cursor_colours[1];
    if (rf[tdac_pkg::IDX_CONTROL][0]) begin
      cols.colour0 = {tdac_pkg::widen6(cursor_colours[0][23:16]),
                      tdac_pkg::widen6(cursor_colours[0][15:8]),
                      tdac_pkg::widen6(cursor_colours[0][7:0])};
      cols.colour1 = {tdac_pkg::widen6(cursor_colours[1][23:16]),
                      tdac_pkg::widen6(cursor_colours[1][15:8]),
                      tdac_pkg::widen6(cursor_colours[1][7:0])};
    end
  end

endmodule

// ===== sv/tdac_lane.sv =====
module tdac_lane (
  input  logic                   active,
  input  logic [1:0]             code,
  input  logic [31:0]            screen,
  input  tdac_pkg::cursor_cols_t cols,
  output logic [31:0]            pixel
);

  always_comb begin
    pixel = screen;
    if (active) begin
      case (tdac_pkg::cursor_code_t'(code))
        tdac_pkg::CUR_COLOUR0: pixel = {8'd0, cols.colour0};
        tdac_pkg::CUR_COLOUR1: pixel = {8'd0, cols.colour1};
        tdac_pkg::CUR_INVERT:  pixel = {screen[31:24], screen[23:0] ^ tdac_pkg::RGB_MASK};
        default:               pixel = screen;
      endcase
    end
  end

endmodule

// ===== sv/truecolor_dac_registers_and_cursor.sv =====
// Register block and two-colour cursor overlay of a truecolor video DAC. One beat in, one
// beat out: a bus write, a bus read or a group of four cursor pixels, with the operation
// carried on s_tuser and the VGA forward flag of the result on m_tuser. Four overlay lanes
// handle the pixels of a group side by side and the register block answers in the same
// cycle, so a beat can be accepted on every clock while the skid stage is empty. The result
// is registered in the output register; a skid stage behind it takes one more beat while
// the output stalls, then holds s_tready low until the output is taken. Register state changes
// as the write is taken, and pixel_format of a result already reflects a write to the format
// register in it.
module truecolor_dac_registers_and_cursor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // operation[1:0]
  input  logic [1:0]                    s_tuser,
  // reg_index[3:0], write_data[11:4], cursor_byte[19:12],
  // screen_pixel_0[51:20], screen_pixel_1[83:52], screen_pixel_2[115:84],
  // screen_pixel_3[147:116], zero pad[151:148]
  input  logic [tdac_pkg::IN_BITS-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // forward_to_vga[0]
  output logic                          m_tuser,
  // read_data[7:0], pixel_format[10:8], out_pixel_0[42:11],
  // out_pixel_1[74:43], out_pixel_2[106:75], out_pixel_3[138:107], zero pad[143:139]
  output logic [tdac_pkg::OUT_BITS-1:0] m_tdata
);

  logic                   accept;
  logic                   take;
  tdac_pkg::bus_req_t     req;
  logic [7:0]             cursor_byte;
  logic [31:0]            screen [tdac_pkg::LANES];
  logic [31:0]            lane_px [tdac_pkg::LANES];
  logic [31:0]            out_px [tdac_pkg::LANES];
  logic [7:0]             read_data;
  logic                   forward_to_vga;
  tdac_pkg::fmt_t         pixel_format;
  tdac_pkg::cursor_cols_t cols;
  logic [tdac_pkg::OUT_BITS-1:0] result;
  logic [tdac_pkg::OUT_BITS-1:0] skid_data;
  logic                   skid_user;
  logic                   skid_valid;

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign take     = m_tvalid && m_tready;

  assign req.op      = tdac_pkg::op_t'(s_tuser);
  assign req.idx     = s_tdata[3:0];
  assign req.wdata   = s_tdata[11:4];
  assign cursor_byte = s_tdata[19:12];
  assign screen[0]   = s_tdata[51:20];
  assign screen[1]   = s_tdata[83:52];
  assign screen[2]   = s_tdata[115:84];
  assign screen[3]   = s_tdata[147:116];

  tdac_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .req            (req),
    .read_data      (read_data),
    .forward_to_vga (forward_to_vga),
    .pixel_format   (pixel_format),
    .cols           (cols)
  );

  for (genvar g = 0; g < tdac_pkg::LANES; g++) begin : g_lane
    tdac_lane u_lane (
      .active (1'(g < tdac_pkg::CURSOR_PIXELS_PER_ITEM)),
      .code   (cursor_byte[2*g +: 2]),
      .screen (screen[g]),
      .cols   (cols),
      .pixel  (lane_px[g])
    );
    assign out_px[g] = (req.op == tdac_pkg::OP_CURSOR) ? lane_px[g] : 32'd0;
  end

  assign result = {5'd0, out_px[3], out_px[2], out_px[1], out_px[0],
                   pixel_format, read_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        m_tdata    <= skid_data;
        m_tuser    <= skid_user;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
        if (accept) begin
          m_tdata <= result;
          m_tuser <= forward_to_vga;
        end
      end
    end else if (accept) begin
      if (!m_tvalid) begin
        m_tdata  <= result;
        m_tuser  <= forward_to_vga;
        m_tvalid <= 1'b1;
      end else begin
        skid_data  <= result;
        skid_user  <= forward_to_vga;
        skid_valid <= 1'b1;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid holds a beat while output is empty");

  a_fill_out: assert property (@(posedge clk) disable iff (rst)
    accept && !m_tvalid |=> m_tvalid)
    else $error("accepted beat did not reach output");

  a_fill_skid: assert property (@(posedge clk) disable iff (rst)
    accept && m_tvalid && !m_tready |=> skid_valid)
    else $error("beat lost on stalled output");

  a_vga_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[7:0] == 8'd0 && m_tdata[138:11] == '0)
    else $error("forwarded access carries data");

endmodule
